>>> hdl/rgb_to_hsv_unit_macros.svh
// Assertion macros for the rgb_to_hsv_unit RTL.
`ifndef RGB_TO_HSV_UNIT_MACROS_SVH
`define RGB_TO_HSV_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_unit: implication check failed");
`define RTH_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("rgb_to_hsv_unit: delayed check failed");
`else
`define RTH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RTH_ASSERT_DELAY(label, clk, rst, ante, n, cons)
`endif
`endif

>>> hdl/rth_pkg.sv
`default_nettype none
package rth_pkg;

  localparam int COMPONENT_BITS_DEFAULT = 8;
  localparam int HUE_BITS   = 15;
  localparam int HUE_Q_BITS = 12;
  localparam int HUE_SUM_BITS = HUE_BITS + 2;
  localparam int HUE_SIXTY  = 3840;
  localparam int HUE_FULL   = 23040;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    neg;
    logic    gray;
  } rth_ctl_t;

  function automatic logic [HUE_BITS-1:0] sector_base(input sector_t s);
    logic [HUE_BITS-1:0] base;
    unique case (s)
      SECTOR_RED:   base = '0;
      SECTOR_GREEN: base = HUE_BITS'(2 * HUE_SIXTY);
      SECTOR_BLUE:  base = HUE_BITS'(4 * HUE_SIXTY);
      default:      base = '0;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rgb_to_hsv_unit.sv
// From start to done an item passes the front-end stages, then the two restoring dividers,
// which run side by side with one quotient bit per stage, then the output register.
// Throughput: one item per clock; busy stays low.
// rst is synchronous and clears the valid bits; items in flight are dropped.
// done is a one-cycle strobe; the receiver cannot hold results off.
`default_nettype none
`include "rgb_to_hsv_unit_macros.svh"
module rgb_to_hsv_unit #(
  parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [COMPONENT_BITS-1:0]    red,
  input  logic [COMPONENT_BITS-1:0]    green,
  input  logic [COMPONENT_BITS-1:0]    blue,
  output logic                         done,
  output logic [rth_pkg::HUE_BITS-1:0] hue,
  output logic [COMPONENT_BITS-1:0]    saturation,
  output logic [COMPONENT_BITS-1:0]    value
);
  import rth_pkg::*;

  localparam int W         = COMPONENT_BITS;
  localparam int DIV_BITS  = (W > HUE_Q_BITS) ? W : HUE_Q_BITS;
  localparam int HNUM_BITS = W + HUE_Q_BITS;
  localparam int SNUM_BITS = 2 * W;
  localparam int CTL_BITS  = $bits(rth_ctl_t);
  localparam int TAG_BITS  = W + CTL_BITS;
  localparam int LATENCY   = DIV_BITS + 3;

  logic                 f_valid;
  rth_ctl_t             f_ctl;
  logic [W-1:0]         f_value;
  logic [W-1:0]         f_delta;
  logic [HNUM_BITS-1:0] f_hnum;
  logic [SNUM_BITS-1:0] f_snum;

  logic                 hq_valid;
  logic [DIV_BITS-1:0]  hq_quo;
  logic [TAG_BITS-1:0]  hq_tag;
  logic                 sq_valid;
  logic [DIV_BITS-1:0]  sq_quo;
  logic [0:0]           sq_tag;

  rth_ctl_t                h_ctl;
  logic [W-1:0]            h_value;
  logic [HUE_Q_BITS-1:0]   h_q;
  logic [HUE_BITS-1:0]     h_base;
  logic [HUE_SUM_BITS-1:0] hue_sum;
  logic [HUE_SUM_BITS-1:0] hue_wrap;
  logic [HUE_BITS-1:0]     hue_next;
  logic [W-1:0]            saturation_next;

  assign busy = 1'b0;

  rth_front #(
    .COMPONENT_BITS(W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .out_valid(f_valid),
    .out_ctl  (f_ctl),
    .out_value(f_value),
    .out_delta(f_delta),
    .out_hnum (f_hnum),
    .out_snum (f_snum)
  );

  rth_div #(
    .NUM_BITS(HNUM_BITS),
    .DEN_BITS(W),
    .QUO_BITS(DIV_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_hue_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .num      (f_hnum),
    .den      (f_delta),
    .in_tag   ({f_value, f_ctl}),
    .out_valid(hq_valid),
    .quo      (hq_quo),
    .out_tag  (hq_tag)
  );

  rth_div #(
    .NUM_BITS(SNUM_BITS),
    .DEN_BITS(W),
    .QUO_BITS(DIV_BITS),
    .TAG_BITS(1)
  ) u_sat_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .num      (f_snum),
    .den      (f_value),
    .in_tag   (f_ctl.gray),
    .out_valid(sq_valid),
    .quo      (sq_quo),
    .out_tag  (sq_tag)
  );

  // final stage: sector offset, sign, wrap below zero, zero hue and saturation for gray
  always_comb begin
    h_ctl    = rth_ctl_t'(hq_tag[CTL_BITS-1:0]);
    h_value  = hq_tag[TAG_BITS-1:CTL_BITS];
    h_q      = hq_quo[HUE_Q_BITS-1:0];
    h_base   = sector_base(h_ctl.sector);
    hue_sum  = h_ctl.neg ? (HUE_SUM_BITS'(h_base) - HUE_SUM_BITS'(h_q))
                         : (HUE_SUM_BITS'(h_base) + HUE_SUM_BITS'(h_q));
    hue_wrap = hue_sum + HUE_SUM_BITS'(HUE_FULL);
    if (h_ctl.gray) begin
      hue_next = '0;
    end else if (hue_sum[HUE_SUM_BITS-1]) begin
      hue_next = hue_wrap[HUE_BITS-1:0];
    end else begin
      hue_next = hue_sum[HUE_BITS-1:0];
    end
    saturation_next = sq_tag[0] ? '0 : sq_quo[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hq_valid;
    end
  end

  always_ff @(posedge clk) begin
    hue        <= hue_next;
    saturation <= saturation_next;
    value      <= h_value;
  end

  `RTH_ASSERT_IMPL(a_div_aligned, clk, rst, hq_valid || sq_valid, hq_valid && sq_valid)
  `RTH_ASSERT_IMPL(a_hue_range, clk, rst, done, hue < HUE_BITS'(HUE_FULL))
  `RTH_ASSERT_IMPL(a_black, clk, rst, done && value == '0, hue == '0 && saturation == '0)
  `RTH_ASSERT_DELAY(a_latency, clk, rst, start && !busy, LATENCY, done)

endmodule
`default_nettype wire

>>> hdl/rth_front.sv
`default_nettype none
module rth_front #(
  parameter int COMPONENT_BITS = rth_pkg::COMPONENT_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [COMPONENT_BITS-1:0]                     red,
  input  logic [COMPONENT_BITS-1:0]                     green,
  input  logic [COMPONENT_BITS-1:0]                     blue,
  output logic                                          out_valid,
  output rth_pkg::rth_ctl_t                             out_ctl,
  output logic [COMPONENT_BITS-1:0]                     out_value,
  output logic [COMPONENT_BITS-1:0]                     out_delta,
  output logic [COMPONENT_BITS+rth_pkg::HUE_Q_BITS-1:0] out_hnum,
  output logic [2*COMPONENT_BITS-1:0]                   out_snum
);
  import rth_pkg::*;

  localparam int W = COMPONENT_BITS;
  localparam int HNUM_BITS = W + HUE_Q_BITS;
  localparam int SNUM_BITS = 2 * W;
  localparam logic [W-1:0] FULL = '1;

  logic          r_ge_g;
  logic          r_ge_b;
  logic          b_ge_g;
  sector_t       sector_c;
  logic [W-1:0]  max_c;
  logic [W-1:0]  min_c;
  logic [W-1:0]  pa;
  logic [W-1:0]  pb;
  logic          neg_c;
  logic [W-1:0]  absd_c;

  logic          s1_valid;
  sector_t       s1_sector;
  logic [W-1:0]  s1_max;
  logic [W-1:0]  s1_min;
  logic [W-1:0]  s1_absd;
  logic          s1_neg;

  logic [W-1:0]  delta_c;

  // stage 1: max, min, sector and |d|
  always_comb begin
    r_ge_g = red >= green;
    r_ge_b = red >= blue;
    b_ge_g = blue >= green;
    priority if (r_ge_g && r_ge_b) begin
      sector_c = SECTOR_RED;
      max_c    = red;
      pa       = green;
      pb       = blue;
    end else if (b_ge_g) begin
      sector_c = SECTOR_BLUE;
      max_c    = blue;
      pa       = red;
      pb       = green;
    end else begin
      sector_c = SECTOR_GREEN;
      max_c    = green;
      pa       = blue;
      pb       = red;
    end
    priority if (red <= green && red <= blue) begin
      min_c = red;
    end else if (green <= blue) begin
      min_c = green;
    end else begin
      min_c = blue;
    end
    neg_c  = pb > pa;
    absd_c = neg_c ? (pb - pa) : (pa - pb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_sector <= sector_c;
    s1_max    <= max_c;
    s1_min    <= min_c;
    s1_absd   <= absd_c;
    s1_neg    <= neg_c;
  end

  // stage 2: delta and the two dividends
  assign delta_c = s1_max - s1_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl.sector <= s1_sector;
    out_ctl.neg    <= s1_neg;
    out_ctl.gray   <= (delta_c == '0);
    out_value      <= s1_max;
    out_delta      <= delta_c;
    out_hnum       <= HNUM_BITS'(s1_absd) * HNUM_BITS'(HUE_SIXTY);
    out_snum       <= SNUM_BITS'(delta_c) * SNUM_BITS'(FULL);
  end

endmodule
`default_nettype wire

>>> hdl/rth_div.sv
`default_nettype none
module rth_div #(
  parameter int NUM_BITS = 2 * rth_pkg::COMPONENT_BITS_DEFAULT,
  parameter int DEN_BITS = rth_pkg::COMPONENT_BITS_DEFAULT,
  parameter int QUO_BITS = rth_pkg::HUE_Q_BITS,
  parameter int TAG_BITS = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                out_valid,
  output logic [QUO_BITS-1:0] quo,
  output logic [TAG_BITS-1:0] out_tag
);
  import rth_pkg::*;

  localparam int RW = DEN_BITS + QUO_BITS;

  logic                val_s [1:QUO_BITS];
  logic [RW-1:0]       rem_s [1:QUO_BITS-1];
  logic [DEN_BITS-1:0] den_s [1:QUO_BITS-1];
  logic [QUO_BITS-1:0] quo_s [1:QUO_BITS];
  logic [TAG_BITS-1:0] tag_s [1:QUO_BITS];

  // restoring division, one quotient bit per stage, MSB first
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    localparam int SHIFT = QUO_BITS - 1 - i;
    logic                v_in;
    logic [RW-1:0]       r_in;
    logic [DEN_BITS-1:0] d_in;
    logic [QUO_BITS-1:0] q_in;
    logic [TAG_BITS-1:0] t_in;
    logic [RW-1:0]       trial;
    logic                fits;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = RW'(num);
      assign d_in = den;
      assign q_in = '0;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = val_s[i];
      assign r_in = rem_s[i];
      assign d_in = den_s[i];
      assign q_in = quo_s[i];
      assign t_in = tag_s[i];
    end

    assign trial = RW'(d_in) << SHIFT;
    assign fits  = r_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        val_s[i+1] <= 1'b0;
      end else begin
        val_s[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      quo_s[i+1] <= {q_in[QUO_BITS-2:0], fits};
      tag_s[i+1] <= t_in;
    end

    if (i < QUO_BITS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        rem_s[i+1] <= fits ? (r_in - trial) : r_in;
        den_s[i+1] <= d_in;
      end
    end
  end

  assign out_valid = val_s[QUO_BITS];
  assign quo       = quo_s[QUO_BITS];
  assign out_tag   = tag_s[QUO_BITS];

endmodule
`default_nettype wire
